FILE: sv/bounded_double_ended_list_assert.svh
// Assertion helpers shared by the list engine.
// Each macro samples on clk and is switched off while rst is high.
`ifndef BOUNDED_DOUBLE_ENDED_LIST_ASSERT_SVH
`define BOUNDED_DOUBLE_ENDED_LIST_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define BDEL_ASSERT_IMPL(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("bdel assertion failed");

// The condition must hold in the cycle after the trigger.
`define BDEL_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("bdel assertion failed");

`endif

FILE: sv/bdel_pkg.sv
`timescale 1ns / 1ps
package bdel_pkg;

  localparam int DEFAULT_CAPACITY = 16;

  // Request codes.
  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [2:0] REQ_INSERT     = 3'd2;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd3;
  localparam logic [2:0] REQ_POP_BACK   = 3'd4;
  localparam logic [2:0] REQ_DELETE     = 3'd5;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // Compare unit modes.
  localparam logic [1:0] CMP_GT = 2'd0;
  localparam logic [1:0] CMP_GE = 2'd1;
  localparam logic [1:0] CMP_EQ = 2'd2;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         count;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
  } out_word_t;

endpackage

FILE: sv/bdel_cmp.sv
`timescale 1ns / 1ps
// Shared signed compare unit used by every scan step.
module bdel_cmp (
  input  logic [1:0]         mode,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic               hit
);

  always_comb begin
    case (mode)
      bdel_pkg::CMP_GT: hit = (a > b);
      bdel_pkg::CMP_GE: hit = (a >= b);
      bdel_pkg::CMP_EQ: hit = (a == b);
      default:          hit = 1'b0;
    endcase
  end

endmodule

FILE: sv/bdel_engine.sv
`timescale 1ns / 1ps
`include "bounded_double_ended_list_assert.svh"
// Sequencer that owns the entry memory and runs one request at a time.
module bdel_engine #(
  parameter int CAPACITY = bdel_pkg::DEFAULT_CAPACITY
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  bdel_pkg::in_word_t  req,
  output logic                ready,
  output logic                res_valid,
  input  logic                res_ready,
  output bdel_pkg::out_word_t res
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SREAD = 4'd1;
  localparam logic [3:0] S_SCMP  = 4'd2;
  localparam logic [3:0] S_MOVE  = 4'd3;
  localparam logic [3:0] S_MWR   = 4'd4;
  localparam logic [3:0] S_PUT   = 4'd5;
  localparam logic [3:0] S_FRD   = 4'd6;
  localparam logic [3:0] S_BRD   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]         state;
  logic [CW-1:0]      count;
  logic [CW-1:0]      idx;
  logic [CW-1:0]      pos;
  logic [2:0]         op;
  logic signed [31:0] val;
  logic signed [31:0] front;
  logic [1:0]         status;
  logic               shift_up;

  logic signed [31:0] mem [CAPACITY];
  logic signed [31:0] mem_rdata;
  logic signed [31:0] mem_wdata;
  logic               mem_we;
  logic               mem_re;
  logic [AW-1:0]      mem_waddr;
  logic [AW-1:0]      mem_raddr;

  logic [CW-1:0]      idx_up;
  logic [CW-1:0]      idx_dn;
  logic [CW-1:0]      cnt_last;
  logic               move_go;
  logic [1:0]         cmp_mode;
  logic               cmp_hit;
  logic [31:0]        cnt_ext;

  always_comb begin
    idx_up   = idx + 1'b1;
    idx_dn   = idx - 1'b1;
    cnt_last = count - 1'b1;
    // An insert moves entries up until the gap reaches pos; a removal
    // pulls entries down until the last one has moved.
    move_go  = shift_up ? (idx != pos) : (idx_up < count);
  end

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = idx[AW-1:0];
    mem_wdata = mem_rdata;
    case (state)
      S_SREAD: begin
        mem_re    = 1'b1;
        mem_raddr = idx[AW-1:0];
      end
      S_MOVE: begin
        mem_re    = move_go;
        mem_raddr = shift_up ? idx_dn[AW-1:0] : idx_up[AW-1:0];
      end
      S_MWR: mem_we = 1'b1;
      S_PUT: begin
        mem_we    = 1'b1;
        mem_wdata = val;
      end
      S_FRD: mem_re = (count != '0);
      S_BRD: begin
        mem_re    = 1'b1;
        mem_raddr = cnt_last[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

  always_comb begin
    if (op == bdel_pkg::REQ_DELETE) begin
      cmp_mode = bdel_pkg::CMP_EQ;
    end else if (idx == '0) begin
      cmp_mode = bdel_pkg::CMP_GT;
    end else begin
      cmp_mode = bdel_pkg::CMP_GE;
    end
  end

  bdel_cmp u_cmp (
    .mode (cmp_mode),
    .a    (mem_rdata),
    .b    (val),
    .hit  (cmp_hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            op  <= req.req_type;
            val <= req.value;
            case (req.req_type)
              bdel_pkg::REQ_PUSH_FRONT, bdel_pkg::REQ_PUSH_BACK, bdel_pkg::REQ_INSERT: begin
                if (count == CAP_C) begin
                  status <= bdel_pkg::ST_FULL;
                  state  <= S_FRD;
                end else if (req.req_type == bdel_pkg::REQ_INSERT && count != '0) begin
                  status <= bdel_pkg::ST_OK;
                  idx    <= '0;
                  state  <= S_SREAD;
                end else begin
                  status   <= bdel_pkg::ST_OK;
                  shift_up <= 1'b1;
                  idx      <= count;
                  pos      <= (req.req_type == bdel_pkg::REQ_PUSH_BACK) ? count : '0;
                  state    <= S_MOVE;
                end
              end
              bdel_pkg::REQ_POP_FRONT, bdel_pkg::REQ_POP_BACK: begin
                if (count == '0) begin
                  status <= bdel_pkg::ST_EMPTY;
                  state  <= S_FRD;
                end else begin
                  status   <= bdel_pkg::ST_OK;
                  shift_up <= 1'b0;
                  idx      <= (req.req_type == bdel_pkg::REQ_POP_FRONT) ? '0 : cnt_last;
                  state    <= S_MOVE;
                end
              end
              bdel_pkg::REQ_DELETE: begin
                if (count == '0) begin
                  status <= bdel_pkg::ST_EMPTY;
                  state  <= S_FRD;
                end else begin
                  status <= bdel_pkg::ST_OK;
                  idx    <= '0;
                  state  <= S_SREAD;
                end
              end
              default: begin
                status <= bdel_pkg::ST_OK;
                state  <= S_FRD;
              end
            endcase
          end
        end
        S_SREAD: state <= S_SCMP;
        S_SCMP: begin
          if (cmp_hit) begin
            state <= S_MOVE;
            if (op == bdel_pkg::REQ_DELETE) begin
              shift_up <= 1'b0;
            end else begin
              shift_up <= 1'b1;
              pos      <= idx;
              idx      <= count;
            end
          end else if (idx_up == count) begin
            if (op == bdel_pkg::REQ_DELETE) begin
              status <= bdel_pkg::ST_NOTFOUND;
              state  <= S_FRD;
            end else begin
              shift_up <= 1'b1;
              pos      <= count;
              idx      <= count;
              state    <= S_MOVE;
            end
          end else begin
            idx   <= idx_up;
            state <= S_SREAD;
          end
        end
        S_MOVE: begin
          if (move_go) begin
            state <= S_MWR;
          end else if (shift_up) begin
            state <= S_PUT;
          end else begin
            count <= cnt_last;
            state <= S_FRD;
          end
        end
        S_MWR: begin
          idx   <= shift_up ? idx_dn : idx_up;
          state <= S_MOVE;
        end
        S_PUT: begin
          count <= count + 1'b1;
          state <= S_FRD;
        end
        S_FRD: begin
          if (count == '0) begin
            front <= '0;
            state <= S_DONE;
          end else begin
            state <= S_BRD;
          end
        end
        S_BRD: begin
          front <= mem_rdata;
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign cnt_ext = 32'(count);
  assign ready     = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    res.status      = status;
    res.count       = cnt_ext[4:0];
    res.front_value = front;
    res.back_value  = (count == '0) ? '0 : mem_rdata;
  end

  `BDEL_ASSERT_IMPL(a_count_bound, 1'b1, count <= CAP_C)
  `BDEL_ASSERT_IMPL(a_full_status, res_valid && res.status == bdel_pkg::ST_FULL, count == CAP_C)
  `BDEL_ASSERT_IMPL(a_empty_status, res_valid && res.status == bdel_pkg::ST_EMPTY, count == '0)
  `BDEL_ASSERT_IMPL(a_scan_range, state == S_SREAD, idx < count)
  `BDEL_ASSERT_NEXT(a_start_leaves_idle, start, state != S_IDLE)

endmodule

FILE: sv/bounded_double_ended_list.sv
`timescale 1ns / 1ps
// Bounded ordered double-ended list of up to CAPACITY signed 32-bit values.
// Requests arrive as words on the req channel (valid/ready) and each one
// produces exactly one response word on the rsp channel (valid/ready) with
// a status, the entry count and the front and back values afterwards.
// Requests: push front, push back, ordered insert, pop front, pop back and
// delete first match. Entries live in one memory with a registered read
// port, and a single sequencer walks it with one shared compare unit.
// A push back or a pop back neither scans nor moves entries. A push front
// or pop front moves the entries, and an ordered insert or delete scans
// and moves them one at a time through the memory's single read port, so
// their run time grows with the count of entries.
// One request is in flight at a time; req_ready is high only while the
// sequencer is idle. A finished response waits in an output register, so
// the next request is taken while the receiver stalls; that request then
// holds in its final state until the output register frees up.
// Reset empties the list by clearing the entry count; the memory contents are not cleared
// and nothing beyond the entry count is ever read.
module bounded_double_ended_list #(
  parameter int CAPACITY = bdel_pkg::DEFAULT_CAPACITY
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  bdel_pkg::in_word_t  req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output bdel_pkg::out_word_t rsp
);

  logic                eng_ready;
  logic                start;
  logic                res_valid;
  logic                res_ready;
  bdel_pkg::out_word_t res;

  // A request starts the sequencer the moment it is accepted.
  assign req_ready = eng_ready;
  assign start     = req_valid & eng_ready;

  // The engine may hand over a result when the output register is empty or
  // is being drained in this same cycle.
  assign res_ready = !rsp_valid || rsp_ready;

  bdel_engine #(
    .CAPACITY (CAPACITY)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (req),
    .ready     (eng_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // The response word itself needs no reset; it is qualified by rsp_valid.
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp <= res;
    end
  end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
module tb;
  import bdel_pkg::*;

  // The list depth matches the block's default parameter.
  localparam int LIST_DEPTH = DEFAULT_CAPACITY;

  // Request codes that the block treats as no operation.
  localparam logic [2:0] REQ_SPARE_A = 3'd6;
  localparam logic [2:0] REQ_SPARE_B = 3'd7;

  localparam int RANDOM_ITEMS   = 950;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 4 * LIST_DEPTH + 20;

  localparam logic signed [31:0] MAX_VAL = 32'sh7fffffff;
  localparam logic signed [31:0] MIN_VAL = 32'sh80000000;

  typedef enum {ROUND_FILL, ROUND_DRAIN, ROUND_MIXED} round_kind_t;

  // One row of the directed table. Rows with has_rsp set carry a response
  // that is obvious by inspection; the other rows go through the predictor.
  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] val;
    logic               has_rsp;
    out_word_t          rsp;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 20;
  localparam directed_row_t DIRECTED_TABLE [0:DIRECTED_ROWS-1] = '{
    '{REQ_POP_FRONT,  32'sd0,      1'b1, '{ST_EMPTY, 5'd0, 32'sd0, 32'sd0}},
    '{REQ_POP_BACK,   -32'sd1,     1'b1, '{ST_EMPTY, 5'd0, 32'sd0, 32'sd0}},
    '{REQ_DELETE,     32'sd0,      1'b1, '{ST_EMPTY, 5'd0, 32'sd0, 32'sd0}},
    '{REQ_SPARE_A,    32'sd7,      1'b1, '{ST_OK,    5'd0, 32'sd0, 32'sd0}},
    '{REQ_SPARE_B,    MAX_VAL,     1'b1, '{ST_OK,    5'd0, 32'sd0, 32'sd0}},
    '{REQ_PUSH_FRONT, MAX_VAL,     1'b1, '{ST_OK,    5'd1, MAX_VAL, MAX_VAL}},
    '{REQ_PUSH_BACK,  MIN_VAL,     1'b1, '{ST_OK,    5'd2, MAX_VAL, MIN_VAL}},
    '{REQ_INSERT,     -32'sd1,     1'b0, '0},
    '{REQ_INSERT,     32'sd0,      1'b0, '0},
    '{REQ_INSERT,     -32'sd1,     1'b0, '0},
    '{REQ_INSERT,     MAX_VAL,     1'b0, '0},
    '{REQ_SPARE_A,    MIN_VAL,     1'b0, '0},
    '{REQ_DELETE,     32'sd12345,  1'b0, '0},
    '{REQ_DELETE,     MAX_VAL,     1'b0, '0},
    '{REQ_DELETE,     MIN_VAL,     1'b0, '0},
    '{REQ_POP_FRONT,  32'sd0,      1'b0, '0},
    '{REQ_POP_BACK,   32'sd0,      1'b0, '0},
    '{REQ_INSERT,     MIN_VAL,     1'b0, '0},
    '{REQ_PUSH_FRONT, 32'sd5,      1'b0, '0},
    '{REQ_POP_BACK,   MAX_VAL,     1'b0, '0}
  };

  logic      clk;
  logic      rst;
  logic      req_valid;
  logic      req_ready;
  in_word_t  req;
  logic      rsp_valid;
  logic      rsp_ready;
  out_word_t rsp;

  // Mirror of the list contents, front at index 0.
  logic signed [31:0] list_mirror[$];
  // Responses still owed by the block, oldest first.
  out_word_t awaited_rsp_q[$];

  // When set, neither side inserts idle cycles.
  bit          no_idle;
  int unsigned mismatch_count;
  int unsigned words_sent;
  int unsigned random_sent;
  int unsigned deepest_list;
  int unsigned status_seen[4];

  bounded_double_ended_list dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Applies one request word to the mirror and returns the response the
  // block must give for it.
  function automatic out_word_t next_list_response(in_word_t w);
    out_word_t          r;
    logic signed [31:0] v;
    int unsigned        pos;
    int unsigned        depth;
    r = '0;
    r.status = ST_OK;
    v = w.value;
    depth = list_mirror.size();
    case (w.req_type)
      REQ_PUSH_FRONT, REQ_PUSH_BACK, REQ_INSERT: begin
        if (depth >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (w.req_type == REQ_PUSH_BACK) begin
            pos = depth;
          end else if (w.req_type == REQ_PUSH_FRONT || depth == 0 || v < list_mirror[0]) begin
            pos = 0;
          end else begin
            // A head equal to the new value stays in front of it; the
            // search starts at the second entry.
            pos = 1;
            while (pos < depth && list_mirror[pos] < v) pos++;
          end
          list_mirror.insert(pos, v);
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (depth == 0) begin
          r.status = ST_EMPTY;
        end else if (w.req_type == REQ_POP_FRONT) begin
          void'(list_mirror.pop_front());
        end else begin
          void'(list_mirror.pop_back());
        end
      end
      REQ_DELETE: begin
        if (depth == 0) begin
          r.status = ST_EMPTY;
        end else begin
          pos = 0;
          while (pos < depth && list_mirror[pos] != v) pos++;
          if (pos < depth) list_mirror.delete(pos);
          else r.status = ST_NOTFOUND;
        end
      end
      default: ;
    endcase
    depth = list_mirror.size();
    r.count = depth[4:0];
    if (depth != 0) begin
      r.front_value = list_mirror[0];
      r.back_value = list_mirror[depth-1];
    end
    return r;
  endfunction

  function automatic int unsigned draw_idle();
    return no_idle ? 0 : $urandom_range(0, 5);
  endfunction

  function automatic logic signed [31:0] existing_or_random();
    if (list_mirror.size() == 0) return $urandom;
    return list_mirror[$urandom_range(0, list_mirror.size() - 1)];
  endfunction

  // Values cluster around zero and on entries already held so that equal
  // keys, ordered placement and delete hits happen often.
  function automatic logic signed [31:0] pick_list_value();
    case ($urandom_range(0, 9))
      0, 1, 2: return int'($urandom_range(0, 16)) - 8;
      3, 4:    return existing_or_random();
      5: begin
        case ($urandom_range(0, 3))
          0:       return MAX_VAL;
          1:       return MIN_VAL;
          2:       return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] draw_op(round_kind_t kind);
    case (kind)
      ROUND_FILL: begin
        case ($urandom_range(0, 2))
          0:       return REQ_PUSH_FRONT;
          1:       return REQ_PUSH_BACK;
          default: return REQ_INSERT;
        endcase
      end
      ROUND_DRAIN: begin
        case ($urandom_range(0, 2))
          0:       return REQ_POP_FRONT;
          1:       return REQ_POP_BACK;
          default: return REQ_DELETE;
        endcase
      end
      default: begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3:        return REQ_PUSH_FRONT;
          4, 5, 6, 7:        return REQ_PUSH_BACK;
          8, 9, 10, 11, 12:  return REQ_INSERT;
          13, 14:            return REQ_POP_FRONT;
          15, 16:            return REQ_POP_BACK;
          17, 18:            return REQ_DELETE;
          default:           return $urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B;
        endcase
      end
    endcase
  endfunction

  // Presents one request word and holds it until the block takes it. The
  // task is entered and left on a falling edge; valid stays high on exit so
  // that back-to-back words need no dip in between.
  task automatic send_word(in_word_t w, bit has_rsp, out_word_t fixed_rsp);
    int unsigned gap;
    out_word_t   predicted;
    gap = draw_idle();
    if (gap != 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req = w;
    req_valid = 1'b1;
    do @(posedge clk); while (!req_ready);
    predicted = next_list_response(w);
    awaited_rsp_q.push_back(has_rsp ? fixed_rsp : predicted);
    words_sent++;
    if (list_mirror.size() > deepest_list) deepest_list = list_mirror.size();
    @(negedge clk);
  endtask

  task automatic send_random(round_kind_t kind);
    in_word_t w;
    w.req_type = draw_op(kind);
    if (kind == ROUND_DRAIN && w.req_type == REQ_DELETE && $urandom_range(0, 3) != 0)
      w.value = existing_or_random();
    else if (w.req_type == REQ_POP_FRONT || w.req_type == REQ_POP_BACK)
      w.value = $urandom;
    else
      w.value = pick_list_value();
    send_word(w, 1'b0, '0);
    random_sent++;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%08h, got 0x%08h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Reset, then the stimulus. The directed table runs first with random idle
  // gaps on both channels, then random rounds that fill, drain or mix requests.
  initial begin
    round_kind_t   kind;
    in_word_t      w;
    bit            drained_once;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    no_idle = 1'b0;
    drained_once = 1'b0;
    mismatch_count = 0;
    words_sent = 0;
    random_sent = 0;
    deepest_list = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    foreach (DIRECTED_TABLE[i]) begin
      w.req_type = DIRECTED_TABLE[i].op;
      w.value = DIRECTED_TABLE[i].val;
      send_word(w, DIRECTED_TABLE[i].has_rsp, DIRECTED_TABLE[i].rsp);
    end

    while (random_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0:       kind = ROUND_FILL;
        1:       kind = ROUND_DRAIN;
        default: kind = ROUND_MIXED;
      endcase
      no_idle = ($urandom_range(0, 4) == 0);
      case (kind)
        ROUND_FILL: begin
          // Fill to the brim, then knock on the door a few more times.
          while (list_mirror.size() < LIST_DEPTH) send_random(ROUND_FILL);
          repeat ($urandom_range(1, 3)) send_random(ROUND_FILL);
        end
        ROUND_DRAIN: begin
          // Empty the list, then try pops and deletes on nothing.
          while (list_mirror.size() != 0) send_random(ROUND_DRAIN);
          repeat ($urandom_range(1, 2)) send_random(ROUND_DRAIN);
        end
        default: repeat ($urandom_range(5, 40)) send_random(ROUND_MIXED);
      endcase
      // Now and then hold off the sender until the block has answered
      // everything, so the next word lands on a fully idle block.
      if (!drained_once || $urandom_range(0, 5) == 0) begin
        drained_once = 1'b1;
        req_valid = 1'b0;
        do @(negedge clk); while (awaited_rsp_q.size() != 0);
      end
    end
    req_valid = 1'b0;

    while (awaited_rsp_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d request words (%0d directed, %0d random); deepest list %0d of %0d.",
             words_sent, DIRECTED_ROWS, random_sent, deepest_list, LIST_DEPTH);
    $display("Statuses seen: %0d ok, %0d empty, %0d not found, %0d full; %0d mismatches.",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_NOTFOUND],
             status_seen[ST_FULL], mismatch_count);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Response side: draws a stall for every word, then takes the word and
  // compares it with the oldest response still owed.
  initial begin
    int unsigned stall;
    out_word_t   want;
    rsp_ready = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      stall = draw_idle();
      if (stall != 0) begin
        rsp_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ready = 1'b1;
      do @(posedge clk); while (!rsp_valid);
      if (awaited_rsp_q.size() == 0) begin
        $display("%0t ns: unexpected response word, expected none, got 0x%h", $time, rsp);
        mismatch_count++;
      end else begin
        want = awaited_rsp_q.pop_front();
        status_seen[want.status]++;
        check_field("status", 32'(want.status), 32'(rsp.status));
        check_field("count", 32'(want.count), 32'(rsp.count));
        check_field("front_value", want.front_value, rsp.front_value);
        check_field("back_value", want.back_value, rsp.back_value);
      end
      @(negedge clk);
    end
  end

  // Watchdog: a long run of cycles with no word moving on either channel
  // means the block has hung.
  int unsigned quiet_cycles;
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no word moved for %0d cycles, %0d responses outstanding",
               $time, WATCHDOG_LIMIT, awaited_rsp_q.size());
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
